// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL of the chain pool allocator.
// Depends on nothing; simulation only, empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("chk");
`define CHK_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("chk");
`else
`define CHK_IMPLY(label, clk, rst, a, c)
`define CHK_NEXT(label, clk, rst, a, c)
`endif
`endif

// ----- rtl/core/kcpa_pkg.sv -----
// Package of the chain pool allocator: status and command codes.
// Depends on nothing.
package kcpa_pkg;
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_DIR_FULL = 3'd2;
  localparam logic [2:0] ST_POOL_FULL = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_SKIPPED  = 3'd5;
  localparam logic [2:0] ST_BUSY     = 3'd6;
endpackage

// ----- rtl/core/keyed_chain_pool_allocator_top.sv -----
// Keyed chain pool allocator: key directory over a linked node pool.
// Depends on kcpa_pkg and assert_macros.svh.
//
// Usage: drive command, name_key, phone, last_element and node_index with
// start high; the item is taken when busy is low. Exactly one result follows,
// shown for one cycle with done high; the receiver cannot hold it off.
// Node data and links live in a synchronous memory (one read, one write port,
// registered read); directory and node use flags are flip-flops.
// Steps: a read and the first insert element answer from the exec state;
// a later insert element goes on to the link state (the first free node
// comes from a priority search over the use flags, then the old tail gets
// its link write-back). A delete goes from exec to the walk state, which
// fetches the head first and frees one chain node per step, each step
// waiting on the link memory read. Rejections and not-found answer from exec.
// busy stays high from acceptance until the result cycle ends, so the next
// item is taken in the cycle after the result at the earliest.
// Reset clears the directory, the use flags and the insert state at once;
// a free node reads as value 0, no successor, so no clearing pass is needed.
`include "assert_macros.svh"
module keyed_chain_pool_allocator_top import kcpa_pkg::*; #(
  parameter int DIR_SLOTS  = 16,
  parameter int POOL_NODES = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  output logic                          done,
  input  logic [1:0]                    command,
  input  logic [63:0]                   name_key,
  input  logic [VALUE_BITS-1:0]         phone,
  input  logic                          last_element,
  input  logic [$clog2(POOL_NODES)-1:0] node_index,
  output logic [2:0]                    status,
  output logic [$clog2(POOL_NODES)-1:0] node_at,
  output logic [VALUE_BITS-1:0]         node_value,
  output logic [$clog2(POOL_NODES):0]   node_successor,
  output logic                          node_in_use
);
  localparam int NW = $clog2(POOL_NODES);
  localparam int SW = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
  localparam logic [NW:0] LINK_NONE = (NW+1)'(POOL_NODES);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_LINK, S_WALK, S_OUT} state_t;
  typedef struct packed {
    logic [VALUE_BITS-1:0] data;
    logic [NW:0]           link;
  } node_t;

  state_t state;
  node_t  mem [POOL_NODES];
  node_t  rd_data;
  logic   [NW-1:0] rd_addr;
  logic   wr_en;
  logic   [NW-1:0] wr_addr;
  node_t  wr_data;

  logic [DIR_SLOTS-1:0]  slot_valid;
  logic [63:0]           slot_key  [DIR_SLOTS];
  logic [NW-1:0]         slot_head [DIR_SLOTS];
  logic [POOL_NODES-1:0] node_used;
  logic                  insert_open, insert_skipping;
  logic [NW-1:0]         insert_tail;

  logic [1:0]            cmd_r;
  logic [63:0]           key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  last_r;
  logic [NW-1:0]         idx_r, cur, new_node;
  logic [NW:0]           walk_cnt;

  // directory and pool searches
  logic          dup_hit, slot_free_ok, node_free_ok;
  logic [SW-1:0] dup_slot, free_slot;
  logic [NW-1:0] free_node;

  always_comb begin
    dup_hit = 1'b0; dup_slot = '0; slot_free_ok = 1'b0; free_slot = '0;
    for (int i = DIR_SLOTS-1; i >= 0; i--) begin
      if (slot_valid[i] && slot_key[i] == key_r) begin
        dup_hit = 1'b1; dup_slot = SW'(i);
      end
      if (!slot_valid[i]) begin
        slot_free_ok = 1'b1; free_slot = SW'(i);
      end
    end
    node_free_ok = 1'b0; free_node = '0;
    for (int n = POOL_NODES-1; n >= 0; n--) begin
      if (!node_used[n]) begin
        node_free_ok = 1'b1; free_node = NW'(n);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    wr_en = 1'b0; wr_addr = new_node; wr_data = '{data: val_r, link: LINK_NONE};
    rd_addr = idx_r;
    unique case (state)
      S_IDLE: rd_addr = node_index;
      S_EXEC: begin
        // fetch the chain tail for a possible link write
        rd_addr = insert_tail;
        if (cmd_r == CMD_INSERT && !(insert_open && insert_skipping) && node_free_ok &&
            (insert_open || (!dup_hit && slot_free_ok))) begin
          wr_en = 1'b1; wr_addr = free_node;
        end
      end
      S_LINK: begin
        // hook the new node onto the old tail of an open chain
        wr_en = 1'b1; wr_addr = insert_tail;
        wr_data = '{data: rd_data.data, link: {1'b0, new_node}};
      end
      S_WALK: rd_addr = (walk_cnt == '0) ? cur : rd_data.link[NW-1:0];
      S_OUT: rd_addr = idx_r;
      default: rd_addr = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; busy <= 1'b0; done <= 1'b0;
      slot_valid <= '0; node_used <= '0;
      insert_open <= 1'b0; insert_skipping <= 1'b0; insert_tail <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1; cmd_r <= command; key_r <= name_key; val_r <= phone;
            last_r <= last_element; idx_r <= node_index; state <= S_EXEC;
          end
        end
        S_EXEC: begin
          status <= ST_OK; node_at <= '0; node_value <= '0;
          node_successor <= LINK_NONE; node_in_use <= 1'b0;
          state <= S_OUT; done <= 1'b1;
          unique case (cmd_r)
            CMD_INSERT: begin
              if (insert_open && insert_skipping) begin
                status <= ST_SKIPPED;
                if (last_r) begin
                  insert_open <= 1'b0; insert_skipping <= 1'b0;
                end
              end else if (!insert_open && dup_hit) begin
                status <= ST_DUP; insert_open <= !last_r; insert_skipping <= !last_r;
              end else if (!insert_open && !slot_free_ok) begin
                status <= ST_DIR_FULL; insert_open <= !last_r; insert_skipping <= !last_r;
              end else if (!node_free_ok) begin
                status <= ST_POOL_FULL; insert_open <= !last_r; insert_skipping <= !last_r;
              end else begin
                if (!insert_open) begin
                  slot_valid[free_slot] <= 1'b1; slot_key[free_slot] <= key_r;
                  slot_head[free_slot] <= free_node;
                  insert_tail <= free_node;
                end else begin
                  // old tail is being read; hold the result for the link write
                  done <= 1'b0; state <= S_LINK;
                end
                node_used[free_node] <= 1'b1; new_node <= free_node;
                insert_open <= !last_r;
                insert_skipping <= 1'b0;
                node_at <= free_node; node_value <= val_r; node_in_use <= 1'b1;
              end
            end
            CMD_DELETE: begin
              if (insert_open) status <= ST_BUSY;
              else if (!dup_hit) status <= ST_NOT_FOUND;
              else begin
                slot_valid[dup_slot] <= 1'b0;
                cur <= slot_head[dup_slot]; walk_cnt <= '0;
                done <= 1'b0; state <= S_WALK;
              end
            end
            CMD_READ: begin
              node_at <= idx_r;
              if (node_used[idx_r]) begin
                node_value <= rd_data.data; node_successor <= rd_data.link;
                node_in_use <= 1'b1;
              end
            end
            default: status <= ST_SKIPPED;
          endcase
        end
        S_LINK: begin
          // tail was read in the exec cycle; advance the tail to the new node
          insert_tail <= new_node;
          done <= 1'b1; state <= S_OUT;
        end
        S_WALK: begin
          // first cycle after exec has no read yet: fetch head, then follow links
          if (walk_cnt == '0 && !node_used[cur] ) begin
            done <= 1'b1; state <= S_OUT;
          end else begin
            walk_cnt <= walk_cnt + 1'b1;
            if (walk_cnt != '0) begin
              node_used[cur] <= 1'b0;
              if (rd_data.link >= LINK_NONE || walk_cnt == (NW+1)'(POOL_NODES)) begin
                done <= 1'b1; state <= S_OUT;
              end else cur <= rd_data.link[NW-1:0];
            end
          end
        end
        S_OUT: begin
          busy <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK_IMPLY(a_done_busy, clk, rst, done, busy)
  `CHK_NEXT(a_done_once, clk, rst, done, !done)
  `CHK_IMPLY(a_skip_open, clk, rst, insert_skipping, insert_open)
  `CHK_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the keyed chain pool allocator.
// Depends on kcpa_pkg and keyed_chain_pool_allocator_top; predicts each result
// from a local copy of the directory and node pool.
`timescale 1ns / 100ps
module testbench;
  import kcpa_pkg::*;

  localparam int SLOTS = 16;
  localparam int NODES = 64;
  localparam logic [6:0] NO_LINK = 7'd64;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] name_key;
    logic [31:0] phone;
    logic        last_element;
    logic [5:0]  node_index;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  node_at;
    logic [31:0] node_value;
    logic [6:0]  node_successor;
    logic        node_in_use;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] command = '0;
  logic [63:0] name_key = '0;
  logic [31:0] phone = '0;
  logic last_element = 1'b0;
  logic [5:0] node_index = '0;
  wire busy, done, node_in_use;
  wire [2:0] status;
  wire [5:0] node_at;
  wire [31:0] node_value;
  wire [6:0] node_successor;

  keyed_chain_pool_allocator_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .command(command), .name_key(name_key), .phone(phone),
    .last_element(last_element), .node_index(node_index), .status(status),
    .node_at(node_at), .node_value(node_value),
    .node_successor(node_successor), .node_in_use(node_in_use)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic        dir_valid [SLOTS];
  logic [63:0] dir_key [SLOTS];
  logic [5:0]  dir_head [SLOTS];
  logic        pool_used [NODES];
  logic [31:0] pool_data [NODES];
  logic [6:0]  pool_link [NODES];
  logic        chain_open, chain_skipping;
  logic [5:0]  chain_tail;

  answer_t pending_answers[$];
  int errors = 0;
  logic [63:0] known_keys[$];

  function automatic answer_t no_node(logic [2:0] st);
    answer_t a;
    a = '{st, 6'd0, 32'd0, NO_LINK, 1'b0};
    return a;
  endfunction

  function automatic int free_node();
    for (int n = 0; n < NODES; n++) if (!pool_used[n]) return n;
    return -1;
  endfunction

  function automatic answer_t predict_allocator(item_t it);
    int slot, n;
    logic [6:0] cur, nxt;
    answer_t a;
    slot = -1;
    case (it.command)
      CMD_INSERT: begin
        if (chain_open && chain_skipping) begin
          if (it.last_element) begin
            chain_open = 1'b0;
            chain_skipping = 1'b0;
          end
          return no_node(ST_SKIPPED);
        end
        if (!chain_open) begin
          for (int i = 0; i < SLOTS; i++)
            if (dir_valid[i] && dir_key[i] == it.name_key) begin
              chain_open = !it.last_element;
              chain_skipping = !it.last_element;
              return no_node(ST_DUP);
            end
          for (int i = SLOTS - 1; i >= 0; i--) if (!dir_valid[i]) slot = i;
          n = free_node();
          if (slot < 0 || n < 0) begin
            chain_open = !it.last_element;
            chain_skipping = !it.last_element;
            return no_node(slot < 0 ? ST_DIR_FULL : ST_POOL_FULL);
          end
          dir_valid[slot] = 1'b1;
          dir_key[slot] = it.name_key;
          dir_head[slot] = n[5:0];
        end else begin
          n = free_node();
          if (n < 0) begin
            chain_open = !it.last_element;
            chain_skipping = !it.last_element;
            return no_node(ST_POOL_FULL);
          end
          pool_link[chain_tail] = 7'(n);
        end
        pool_used[n] = 1'b1;
        pool_data[n] = it.phone;
        pool_link[n] = NO_LINK;
        chain_tail = n[5:0];
        chain_open = !it.last_element;
        chain_skipping = 1'b0;
        a = '{ST_OK, n[5:0], it.phone, NO_LINK, 1'b1};
        return a;
      end
      CMD_DELETE: begin
        if (chain_open) return no_node(ST_BUSY);
        cur = NO_LINK;
        for (int i = 0; i < SLOTS; i++)
          if (dir_valid[i] && dir_key[i] == it.name_key) begin
            cur = {1'b0, dir_head[i]};
            dir_valid[i] = 1'b0;
            slot = i;
          end
        if (slot < 0) return no_node(ST_NOT_FOUND);
        for (int s = 0; s < NODES && cur < NO_LINK; s++) begin
          nxt = pool_link[cur];
          pool_used[cur] = 1'b0;
          pool_data[cur] = '0;
          pool_link[cur] = NO_LINK;
          cur = nxt;
        end
        return no_node(ST_OK);
      end
      CMD_READ: begin
        a = '{ST_OK, it.node_index,
              pool_used[it.node_index] ? pool_data[it.node_index] : 32'd0,
              pool_link[it.node_index], pool_used[it.node_index]};
        return a;
      end
      default: return no_node(ST_SKIPPED);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  // results are valid for exactly one cycle; sample at the edge that ends it
  always @(posedge clk) begin
    answer_t w;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result", status, 0);
      end else begin
        w = pending_answers.pop_front();
        if (status !== w.status) report_mismatch("status", status, w.status);
        if (node_at !== w.node_at) report_mismatch("node_at", node_at, w.node_at);
        if (node_value !== w.node_value)
          report_mismatch("node_value", node_value, w.node_value);
        if (node_successor !== w.node_successor)
          report_mismatch("node_successor", node_successor, w.node_successor);
        if (node_in_use !== w.node_in_use)
          report_mismatch("node_in_use", node_in_use, w.node_in_use);
      end
    end
  end

  int idle_pct = 11;

  // hold start until the item is taken; optional typed-in answer checked too
  task automatic send_item(item_t it, bit typed, answer_t want);
    answer_t p;
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    command <= it.command;
    name_key <= it.name_key;
    phone <= it.phone;
    last_element <= it.last_element;
    node_index <= it.node_index;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = predict_allocator(it);
    if (typed && p !== want) report_mismatch("directed row", p, want);
    pending_answers.push_back(p);
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic item_t mk(logic [1:0] c, logic [63:0] k, logic [31:0] v,
                               logic l, logic [5:0] x);
    item_t it;
    it = '{c, k, v, l, x};
    return it;
  endfunction

  function automatic logic [63:0] pick_key();
    if (known_keys.size() > 0 && $urandom_range(99) < 60)
      return known_keys[$urandom_range(known_keys.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  typedef struct {
    item_t   it;
    bit      typed;
    answer_t want;
  } row_t;

  initial begin
    row_t table_rows[$];
    answer_t none_ok;
    item_t it;
    logic [63:0] k;
    int len, items;
    none_ok = '{ST_OK, 6'd0, 32'd0, NO_LINK, 1'b0};
    for (int i = 0; i < SLOTS; i++) begin
      dir_valid[i] = 1'b0; dir_key[i] = '0; dir_head[i] = '0;
    end
    for (int n = 0; n < NODES; n++) begin
      pool_used[n] = 1'b0; pool_data[n] = '0; pool_link[n] = NO_LINK;
    end
    chain_open = 1'b0; chain_skipping = 1'b0; chain_tail = '0;

    table_rows.push_back('{mk(CMD_READ, 0, 0, 0, 6'd63), 1,
                           '{ST_OK, 6'd63, 32'd0, NO_LINK, 1'b0}});
    table_rows.push_back('{mk(CMD_DELETE, '1, 0, 0, 0), 1, no_node(ST_NOT_FOUND)});
    table_rows.push_back('{mk(CMD_INSERT, '1, '1, 0, 0), 1,
                           '{ST_OK, 6'd0, 32'hffffffff, NO_LINK, 1'b1}});
    table_rows.push_back('{mk(CMD_INSERT, 0, 0, 0, 0), 0, none_ok});
    table_rows.push_back('{mk(CMD_DELETE, '1, 0, 0, 0), 1, no_node(ST_BUSY)});
    table_rows.push_back('{mk(CMD_INSERT, 5, 32'h5555aaaa, 1, 0), 0, none_ok});
    table_rows.push_back('{mk(CMD_READ, 0, 0, 0, 6'd0), 0, none_ok});
    table_rows.push_back('{mk(CMD_READ, 0, 0, 0, 6'd2), 0, none_ok});
    table_rows.push_back('{mk(CMD_INSERT, '1, 1, 0, 0), 1, no_node(ST_DUP)});
    table_rows.push_back('{mk(CMD_INSERT, 7, 2, 0, 0), 1, no_node(ST_SKIPPED)});
    table_rows.push_back('{mk(CMD_INSERT, 7, 3, 1, 0), 1, no_node(ST_SKIPPED)});
    table_rows.push_back('{mk(CMD_UNUSED, '1, '1, 1, '1), 1, no_node(ST_SKIPPED)});
    table_rows.push_back('{mk(CMD_INSERT, 0, 32'h12345678, 1, '1), 0, none_ok});
    table_rows.push_back('{mk(CMD_DELETE, '1, 0, 0, 0), 1, none_ok});
    table_rows.push_back('{mk(CMD_READ, 0, 0, 0, 6'd1), 0, none_ok});
    table_rows.push_back('{mk(CMD_DELETE, 0, 0, 0, 0), 1, none_ok});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (table_rows[i]) send_item(table_rows[i].it, table_rows[i].typed,
                                      table_rows[i].want);

    // fill the directory to full, then flood the pool to exhaustion
    for (int s = 0; s <= SLOTS; s++)
      send_item(mk(CMD_INSERT, 64'h1000 + s, $urandom, 1, 0), 0, none_ok);
    for (int s = 0; s < SLOTS; s++)
      send_item(mk(CMD_DELETE, 64'h1000 + s, 0, 0, 0), 0, none_ok);
    for (int n = 0; n < NODES + 3; n++)
      send_item(mk(CMD_INSERT, 64'h2000, $urandom, n == NODES + 2, 0), 0, none_ok);
    send_item(mk(CMD_INSERT, 64'h3000, 1, 1, 0), 0, none_ok);
    for (int n = 0; n < NODES; n += 9)
      send_item(mk(CMD_READ, 0, 0, 0, n[5:0]), 0, none_ok);
    send_item(mk(CMD_DELETE, 64'h2000, 0, 0, 0), 0, none_ok);

    // pause until the block has answered everything
    while (pending_answers.size() > 0) @(posedge clk);

    items = 0;
    while (items < 380) begin
      idle_pct = (items >= 150 && items < 250) ? 0 : 11;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          k = pick_key();
          if (known_keys.size() < 24) known_keys.push_back(k);
          len = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 4);
          for (int e = 0; e < len; e++) begin
            send_item(mk(CMD_INSERT, e == 0 ? k : {$urandom, $urandom}, $urandom,
                         e == len - 1, 6'($urandom)), 0, none_ok);
            items++;
          end
        end
        5, 6: begin
          send_item(mk(CMD_DELETE, pick_key(), $urandom, 1'($urandom), 6'($urandom)),
                    0, none_ok);
          items++;
        end
        7, 8: begin
          send_item(mk(CMD_READ, {$urandom, $urandom}, $urandom, 1'($urandom),
                       6'($urandom)), 0, none_ok);
          items++;
        end
        default: begin
          // noise: any command with random fields
          it = mk(2'($urandom), {$urandom, $urandom}, $urandom, 1'($urandom),
                  6'($urandom));
          send_item(it, 0, none_ok);
          items++;
        end
      endcase
    end

    while (pending_answers.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/kcpa_pkg.sv
rtl/core/keyed_chain_pool_allocator_top.sv
sim/testbench.sv
